// ===== src/clsu_pkg.sv =====
package clsu_pkg;

  localparam int MEM_WORDS = 65536;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam logic [MEM_AW-1:0] MEM_LAST = MEM_AW'(MEM_WORDS - 1);

  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = $clog2(NUM_REGS);

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam logic [QUEUE_AW:0]   QUEUE_FULL = (QUEUE_AW + 1)'(QUEUE_DEPTH);
  localparam logic [QUEUE_AW-1:0] QUEUE_LAST = QUEUE_AW'(QUEUE_DEPTH - 1);

  localparam logic [REG_IDX_W-1:0] REG_TEXT_LO  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_TEXT_HI  = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_DATA_LO  = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_DATA_HI  = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_HEAP_LO  = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_HEAP_HI  = REG_IDX_W'(5);
  localparam logic [REG_IDX_W-1:0] REG_STACK_LO = REG_IDX_W'(6);
  localparam logic [REG_IDX_W-1:0] REG_STACK_HI = REG_IDX_W'(7);

  typedef enum logic [1:0] {
    KIND_FETCH = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_STORE = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  localparam logic [1:0] SC_BYTE = 2'd0;
  localparam logic [1:0] SC_HALF = 2'd1;
  localparam logic [1:0] SC_WORD = 2'd2;

  localparam logic [2:0] FLT_OK          = 3'd0;
  localparam logic [2:0] FLT_FETCH_MIS   = 3'd1;
  localparam logic [2:0] FLT_FETCH_OOB   = 3'd2;
  localparam logic [2:0] FLT_LOAD_MIS    = 3'd3;
  localparam logic [2:0] FLT_LOAD_OOB    = 3'd4;
  localparam logic [2:0] FLT_STORE_MIS   = 3'd5;
  localparam logic [2:0] FLT_STORE_OOB   = 3'd6;

  typedef struct packed {
    logic [31:0] text_lo;
    logic [31:0] text_hi;
    logic [31:0] data_lo;
    logic [31:0] data_hi;
    logic [31:0] heap_lo;
    logic [31:0] heap_hi;
    logic [31:0] stack_lo;
    logic [31:0] stack_hi;
  } win_t;

  typedef struct packed {
    logic              mem_op;
    logic [2:0]        fault;
    logic              is_store;
    logic [1:0]        size_code;
    logic              is_signed;
    logic [1:0]        offset;
    logic [MEM_AW-1:0] widx;
    logic [31:0]       sdata;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } back_stat_t;

endpackage

// ===== src/clsu_ram.sv =====
module clsu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/clsu_fifo.sv =====
module clsu_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  clsu_pkg::op_t          push_op,
  input  logic                   pop,
  output clsu_pkg::op_t          head_op,
  output clsu_pkg::fifo_stat_t   stat
);
  import clsu_pkg::*;

  op_t                 entry_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_LAST) ? '0 : wr_ptr_r + QUEUE_AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_LAST) ? '0 : rd_ptr_r + QUEUE_AW'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + (QUEUE_AW + 1)'(1);
      2'b01:   count_nxt = count_r - (QUEUE_AW + 1)'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

  assign head_op    = entry_r[rd_ptr_r];
  assign stat.full  = (count_r == QUEUE_FULL);
  assign stat.empty = (count_r == '0);

endmodule

// ===== src/clsu_front.sv =====
module clsu_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_kind,
  input  logic [1:0]           in_size_code,
  input  logic                 in_is_signed,
  input  logic [31:0]          in_address,
  input  logic [31:0]          in_store_data,
  input  clsu_pkg::win_t       win,
  input  clsu_pkg::fifo_stat_t fifo_stat,
  input  logic                 clearing,
  output logic                 push,
  output clsu_pkg::op_t        op
);
  import clsu_pkg::*;

  function automatic logic span_in(logic [31:0] a, logic [32:0] e,
                                   logic [31:0] lo, logic [31:0] hi);
    return (a >= lo) && (e <= {1'b0, hi});
  endfunction

  logic [1:0]  nsz;
  logic [2:0]  nbytes;
  logic [32:0] end_addr;
  logic        misal;
  logic        wrap;
  logic        in_text;
  logic        in_dls;
  logic [2:0]  fault;

  always_comb begin
    if (in_kind == KIND_FETCH || in_size_code == 2'd3) begin
      nsz = SC_WORD;
    end else begin
      nsz = in_size_code;
    end

    case (nsz)
      SC_BYTE: begin
        nbytes = 3'd1;
        misal  = 1'b0;
        wrap   = &in_address;
      end
      SC_HALF: begin
        nbytes = 3'd2;
        misal  = in_address[0];
        wrap   = &in_address[31:1];
      end
      default: begin
        nbytes = 3'd4;
        misal  = |in_address[1:0];
        wrap   = &in_address[31:2];
      end
    endcase

    end_addr = {1'b0, in_address} + {30'd0, nbytes};
    in_text  = span_in(in_address, end_addr, win.text_lo, win.text_hi);
    in_dls   = span_in(in_address, end_addr, win.data_lo, win.data_hi) ||
               span_in(in_address, end_addr, win.heap_lo, win.heap_hi) ||
               span_in(in_address, end_addr, win.stack_lo, win.stack_hi);

    case (in_kind)
      KIND_FETCH: begin
        fault = misal ? FLT_FETCH_MIS : ((wrap || !in_text) ? FLT_FETCH_OOB : FLT_OK);
      end
      KIND_LOAD: begin
        fault = misal ? FLT_LOAD_MIS : ((wrap || !in_dls) ? FLT_LOAD_OOB : FLT_OK);
      end
      KIND_STORE: begin
        fault = misal ? FLT_STORE_MIS : ((wrap || !in_dls) ? FLT_STORE_OOB : FLT_OK);
      end
      default: begin
        fault = FLT_OK;
      end
    endcase

    op.mem_op    = (in_kind != KIND_NONE) && (fault == FLT_OK);
    op.fault     = fault;
    op.is_store  = (in_kind == KIND_STORE);
    op.size_code = nsz;
    op.is_signed = in_is_signed;
    op.offset    = in_address[1:0];
    op.widx      = in_address[MEM_AW+1:2];
    op.sdata     = in_store_data;
  end

  assign in_ready = !fifo_stat.full && !clearing;
  assign push     = in_valid && in_ready;

endmodule

// ===== src/clsu_back.sv =====
module clsu_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  clsu_pkg::op_t        head_op,
  input  clsu_pkg::fifo_stat_t fifo_stat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_read_data,
  output logic [2:0]           out_fault,
  output clsu_pkg::back_stat_t stat
);
  import clsu_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_MEM   = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [MEM_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  op_t               cur_r;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_rdata_r, out_rdata_nxt;
  logic [2:0]        out_fault_r, out_fault_nxt;
  logic              out_load;
  logic              out_free;

  logic              ram_we;
  logic [MEM_AW-1:0] ram_addr;
  logic [31:0]       ram_wdata;
  logic [31:0]       ram_rdata;

  logic [4:0]        shamt;
  logic [31:0]       shifted;
  logic [31:0]       sdata_sh;
  logic [3:0]        be;
  logic [31:0]       merged;
  logic [31:0]       load_val;

  clsu_ram #(
    .WIDTH (32),
    .DEPTH (MEM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    shamt    = {cur_r.offset, 3'b000};
    shifted  = ram_rdata >> shamt;
    sdata_sh = cur_r.sdata << shamt;
    case (cur_r.size_code)
      SC_BYTE: begin
        be       = 4'b0001 << cur_r.offset;
        load_val = {{24{cur_r.is_signed & shifted[7]}}, shifted[7:0]};
      end
      SC_HALF: begin
        be       = 4'b0011 << cur_r.offset;
        load_val = {{16{cur_r.is_signed & shifted[15]}}, shifted[15:0]};
      end
      default: begin
        be       = 4'b1111;
        load_val = ram_rdata;
      end
    endcase
    for (int i = 0; i < 4; i++) begin
      merged[8*i +: 8] = be[i] ? sdata_sh[8*i +: 8] : ram_rdata[8*i +: 8];
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    pop           = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = head_op.widx;
    ram_wdata     = merged;
    out_load      = 1'b0;
    out_rdata_nxt = '0;
    out_fault_nxt = FLT_OK;
    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_addr    = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + MEM_AW'(1);
        if (clr_cnt_r == MEM_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!fifo_stat.empty && out_free) begin
          pop = 1'b1;
          if (head_op.mem_op) begin
            state_nxt = ST_MEM;
          end else begin
            out_load      = 1'b1;
            out_fault_nxt = head_op.fault;
          end
        end
      end
      ST_MEM: begin
        ram_addr  = cur_r.widx;
        out_load  = 1'b1;
        state_nxt = ST_IDLE;
        if (cur_r.is_store) begin
          ram_we = 1'b1;
        end else begin
          out_rdata_nxt = load_val;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head_op;
    end
    if (out_load) begin
      out_rdata_r <= out_rdata_nxt;
      out_fault_r <= out_fault_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_rdata_r;
  assign out_fault     = out_fault_r;
  assign stat.clearing = (state_r == ST_CLEAR);
  assign stat.busy     = (state_r == ST_MEM);

endmodule

// ===== src/checked_load_store_unit_core.sv =====
// Checked load/store port with window checks over a word-wide local memory.
// Input channel (in_*): one access per beat - fetch, load or store with size,
// signedness, byte address and store data. Output channel (out_*): exactly
// one beat per accepted access, in order, carrying read data and fault code.
// Configuration (cfg_*): write the eight window bounds only while idle.
// A front stage checks alignment, top-of-space wrap and windows as a beat is
// accepted and queues the result in a two-entry queue; a back sequencer owns
// the single-port RAM with registered read.
// Flow: each access is queued; once popped, a faulting or ignored access
// loads the output register, and a memory access reads RAM and enters MEM.
// Throughput: one faulting access per cycle while out_ready is high; a
// memory access holds the RAM port (read, then data return or merged write).
// Reset: window bounds return to zero and the back sequencer sweeps the RAM
// to zero, one word a cycle, across MEM_WORDS (65536) words; in_ready stays
// low meanwhile.
// When out_ready is low the result holds in the output register, the back
// stops taking queue entries and the front keeps accepting until the queue
// fills.
module checked_load_store_unit_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_kind,
  input  logic [1:0]                     in_size_code,
  input  logic                           in_is_signed,
  input  logic [31:0]                    in_address,
  input  logic [31:0]                    in_store_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [31:0]                    out_read_data,
  output logic [2:0]                     out_fault,
  input  logic                           cfg_wr_en,
  input  logic [clsu_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata
);
  import clsu_pkg::*;

  logic [31:0] cfg_regs_r [NUM_REGS];
  win_t        win;
  fifo_stat_t  fifo_stat;
  back_stat_t  back_stat;
  op_t         push_op;
  op_t         head_op;
  logic        push;
  logic        pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_regs_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      cfg_regs_r[cfg_index] <= cfg_wdata;
    end
  end

  assign win.text_lo  = cfg_regs_r[REG_TEXT_LO];
  assign win.text_hi  = cfg_regs_r[REG_TEXT_HI];
  assign win.data_lo  = cfg_regs_r[REG_DATA_LO];
  assign win.data_hi  = cfg_regs_r[REG_DATA_HI];
  assign win.heap_lo  = cfg_regs_r[REG_HEAP_LO];
  assign win.heap_hi  = cfg_regs_r[REG_HEAP_HI];
  assign win.stack_lo = cfg_regs_r[REG_STACK_LO];
  assign win.stack_hi = cfg_regs_r[REG_STACK_HI];

  clsu_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_size_code  (in_size_code),
    .in_is_signed  (in_is_signed),
    .in_address    (in_address),
    .in_store_data (in_store_data),
    .win           (win),
    .fifo_stat     (fifo_stat),
    .clearing      (back_stat.clearing),
    .push          (push),
    .op            (push_op)
  );

  clsu_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .stat    (fifo_stat)
  );

  clsu_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_op       (head_op),
    .fifo_stat     (fifo_stat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_data (out_read_data),
    .out_fault     (out_fault),
    .stat          (back_stat)
  );

`ifndef SYNTHESIS
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.clearing |-> !in_ready)
    else $error("input beat accepted during memory sweep");

  a_fault_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_fault != FLT_OK) |-> (out_read_data == '0))
    else $error("faulting beat carries read data");

  a_no_result_at_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(back_stat.clearing) |-> !out_valid)
    else $error("result produced before memory sweep finished");

  a_pop_only_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.busy |-> !pop)
    else $error("queue popped while memory access in flight");
`endif

endmodule

// ===== test/lsu_result_checker.sv =====
`timescale 1ns / 100ps
module lsu_result_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [1:0]                     in_kind,
  input  logic [1:0]                     in_size_code,
  input  logic                           in_is_signed,
  input  logic [31:0]                    in_address,
  input  logic [31:0]                    in_store_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [31:0]                    out_read_data,
  input  logic [2:0]                     out_fault,
  input  logic                           cfg_wr_en,
  input  logic [clsu_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata,
  output int                             n_fail,
  output int                             n_pending,
  output int                             n_checked
);
  import clsu_pkg::*;

  typedef struct packed {
    logic [31:0] read_data;
    logic [2:0]  fault;
  } beat_t;

  beat_t     due_q[$];
  win_t      win;
  bit [31:0] mem_img [MEM_WORDS];
  int        fails = 0;
  int        checked = 0;

  function automatic logic fits(input logic [31:0] addr, input logic [2:0] nbytes,
                                input logic [31:0] lo, input logic [31:0] hi);
    logic [32:0] span_end;
    span_end = {1'b0, addr} + 33'(nbytes);
    return (addr >= lo) && (span_end <= {1'b0, hi});
  endfunction

  function automatic beat_t lsu_outcome(input logic [1:0] kind, input logic [1:0] size_code,
                                        input logic is_signed, input logic [31:0] addr,
                                        input logic [31:0] sdata);
    beat_t             res;
    logic [2:0]        nbytes;
    logic [31:0]       mask;
    logic [31:0]       val;
    logic [4:0]        shift;
    logic [MEM_AW-1:0] widx;
    logic              is_load;
    logic              in_win;
    res = '0;
    widx = addr[MEM_AW+1:2];
    shift = {addr[1:0], 3'b000};
    case (size_code)
      SC_BYTE: nbytes = 3'd1;
      SC_HALF: nbytes = 3'd2;
      default: nbytes = 3'd4;
    endcase
    mask = (nbytes == 3'd4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * nbytes)) - 32'd1);
    is_load = (kind == KIND_LOAD);
    case (kind)
      KIND_FETCH: begin
        if (addr[1:0] != 2'b00)
          res.fault = FLT_FETCH_MIS;
        else if (addr >= 32'hFFFF_FFFC || !fits(addr, 3'd4, win.text_lo, win.text_hi))
          res.fault = FLT_FETCH_OOB;
        else
          res.read_data = mem_img[widx];
      end
      KIND_LOAD, KIND_STORE: begin
        in_win = fits(addr, nbytes, win.data_lo, win.data_hi) ||
                 fits(addr, nbytes, win.heap_lo, win.heap_hi) ||
                 fits(addr, nbytes, win.stack_lo, win.stack_hi);
        if ((addr & (32'(nbytes) - 32'd1)) != 32'd0) begin
          res.fault = is_load ? FLT_LOAD_MIS : FLT_STORE_MIS;
        end else if (addr >= (32'd0 - 32'(nbytes)) || !in_win) begin
          res.fault = is_load ? FLT_LOAD_OOB : FLT_STORE_OOB;
        end else if (is_load) begin
          val = (mem_img[widx] >> shift) & mask;
          if (is_signed && nbytes != 3'd4 && val[8*nbytes-1])
            val = val | ~mask;
          res.read_data = val;
        end else begin
          mem_img[widx] = (mem_img[widx] & ~(mask << shift)) | ((sdata & mask) << shift);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : score
    beat_t want;
    if (!rst_n) begin
      win = '0;
      due_q.delete();
      fails = 0;
      checked = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_TEXT_LO:  win.text_lo  = cfg_wdata;
          REG_TEXT_HI:  win.text_hi  = cfg_wdata;
          REG_DATA_LO:  win.data_lo  = cfg_wdata;
          REG_DATA_HI:  win.data_hi  = cfg_wdata;
          REG_HEAP_LO:  win.heap_lo  = cfg_wdata;
          REG_HEAP_HI:  win.heap_hi  = cfg_wdata;
          REG_STACK_LO: win.stack_lo = cfg_wdata;
          REG_STACK_HI: win.stack_hi = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        due_q.push_back(lsu_outcome(in_kind, in_size_code, in_is_signed, in_address,
                                    in_store_data));
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%t: result beat with nothing due: data %h fault %0d",
                     $time, out_read_data, out_fault);
        end else begin
          want = due_q.pop_front();
          checked++;
          if (out_read_data !== want.read_data || out_fault !== want.fault) begin
            fails++;
            if (fails <= 10)
              $display("%t: beat %0d: want data %h fault %0d, got data %h fault %0d",
                       $time, checked, want.read_data, want.fault, out_read_data, out_fault);
          end
        end
      end
    end
    n_fail    <= fails;
    n_pending <= due_q.size();
    n_checked <= checked;
  end

endmodule

// ===== test/tb_checked_load_store_unit_core.sv =====
`timescale 1ns / 100ps
module tb_checked_load_store_unit_core;
  import clsu_pkg::*;

  localparam int         CYCLE_LIMIT = 400000;
  localparam int         HOLD_CYCLES = 200;
  localparam int         DRAIN_CYCLES = 8;
  localparam logic [1:0] SC_SPARE = 2'd3;

  localparam win_t WIN_A = '{text_lo: 32'h0000_1000, text_hi: 32'h0000_2000,
                             data_lo: 32'h0001_0000, data_hi: 32'h0001_0400,
                             heap_lo: 32'h0004_1000, heap_hi: 32'h0004_1800,
                             stack_lo: 32'hFFFF_F000, stack_hi: 32'hFFFF_FFFF};
  localparam win_t WIN_FULL = '{text_lo: 32'h0, text_hi: 32'hFFFF_FFFF,
                                data_lo: 32'h0, data_hi: 32'hFFFF_FFFF,
                                heap_lo: 32'hFFFF_FFFF, heap_hi: 32'hFFFF_FFFF,
                                stack_lo: 32'hFFFF_FFFF, stack_hi: 32'h0};
  localparam win_t WIN_SHUT = '{text_lo: 32'h0000_1000, text_hi: 32'h0000_1000,
                                data_lo: 32'h0000_2000, data_hi: 32'h0000_1000,
                                heap_lo: 32'h0, heap_hi: 32'h0,
                                stack_lo: 32'h8000_0000, stack_hi: 32'h7FFF_FFFF};

  typedef enum logic [1:0] {
    RX_RANDOM,
    RX_HOLD,
    RX_OPEN
  } rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_kind;
  logic [1:0]           in_size_code;
  logic                 in_is_signed;
  logic [31:0]          in_address;
  logic [31:0]          in_store_data;
  logic                 out_valid;
  logic                 out_ready;
  logic [31:0]          out_read_data;
  logic [2:0]           out_fault;
  logic                 cfg_wr_en;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_wdata;

  int       n_fail;
  int       n_pending;
  int       n_checked;
  int       n_sent = 0;
  int       n_settings = 0;
  int       cycle_count = 0;
  win_t     cur_win = '0;
  rx_mode_t rx_mode;
  logic     tx_gaps = 1'b1;

  always #1 clk = ~clk;

  checked_load_store_unit_core u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_size_code  (in_size_code),
    .in_is_signed  (in_is_signed),
    .in_address    (in_address),
    .in_store_data (in_store_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_data (out_read_data),
    .out_fault     (out_fault),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  lsu_result_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_size_code  (in_size_code),
    .in_is_signed  (in_is_signed),
    .in_address    (in_address),
    .in_store_data (in_store_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_data (out_read_data),
    .out_fault     (out_fault),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .n_fail        (n_fail),
    .n_pending     (n_pending),
    .n_checked     (n_checked)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic put_access(input kind_t kind, input logic [1:0] sc, input logic sgn,
                            input logic [31:0] addr, input logic [31:0] sdata);
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_size_code  <= sc;
    in_is_signed  <= sgn;
    in_address    <= addr;
    in_store_data <= sdata;
    do @(posedge clk); while (!in_ready);
    n_sent++;
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // hold the input until every due result has come back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_windows(input win_t w);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= REG_IDX_W'(i);
      cfg_wdata <= w[(NUM_REGS-1-i)*32 +: 32];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    cur_win = w;
    n_settings++;
  endtask

  function automatic win_t random_windows();
    logic [31:0] b [NUM_REGS];
    for (int i = 0; i < NUM_REGS; i += 2) begin
      b[i] = (($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0004_0000))
             & 32'hFFFF_FFF0;
      case ($urandom_range(0, 5))
        0: b[i+1] = b[i];
        1: b[i+1] = b[i] - $urandom_range(1, 64);
        2: b[i+1] = $urandom;
        default: b[i+1] = b[i] + $urandom_range(4, 512);
      endcase
    end
    return {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]};
  endfunction

  function automatic logic [31:0] pick_addr(input kind_t kind, input logic [2:0] nbytes);
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] a;
    int unsigned sel;
    if (kind == KIND_FETCH)
      sel = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    else
      sel = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
    lo = cur_win[(NUM_REGS-1-2*sel)*32 +: 32];
    hi = cur_win[(NUM_REGS-2-2*sel)*32 +: 32];
    case ($urandom_range(0, 9))
      6: a = hi - $urandom_range(0, 8);
      7: a = lo - $urandom_range(0, 4);
      8: a = $urandom;
      9: a = 32'hFFFF_FFF0 + $urandom_range(0, 15);
      default: a = lo + $urandom_range(0, 255);
    endcase
    if ($urandom_range(0, 9) != 0)
      a = a & ~(32'(nbytes) - 32'd1);
    return a;
  endfunction

  task automatic run_random(input int n_items);
    int          done_n;
    int unsigned r;
    kind_t       k;
    logic [1:0]  sc;
    logic [2:0]  nbytes;
    done_n = 0;
    while (done_n < n_items) begin
      r = $urandom_range(0, 19);
      k = (r < 4) ? KIND_FETCH : (r < 11) ? KIND_LOAD : (r < 19) ? KIND_STORE : KIND_NONE;
      r = $urandom_range(0, 9);
      sc = (r < 3) ? SC_BYTE : (r < 6) ? SC_HALF : (r < 9) ? SC_WORD : SC_SPARE;
      if (k == KIND_FETCH || sc == SC_WORD || sc == SC_SPARE)
        nbytes = 3'd4;
      else
        nbytes = (sc == SC_HALF) ? 3'd2 : 3'd1;
      put_access(k, sc, 1'($urandom), pick_addr(k, nbytes), $urandom);
      if (k != KIND_NONE)
        done_n++;
    end
  endtask

  task automatic run_directed();
    put_access(KIND_FETCH, SC_WORD, 1'b0, 32'h0000_1000, 32'h0);
    put_access(KIND_FETCH, SC_BYTE, 1'b1, 32'h0000_1002, 32'h0);
    put_access(KIND_FETCH, SC_WORD, 1'b0, 32'h0001_0000, 32'h0);
    put_access(KIND_FETCH, SC_WORD, 1'b0, 32'h0000_1FFC, 32'h0);
    put_access(KIND_FETCH, SC_WORD, 1'b0, 32'h0000_2000, 32'h0);
    put_access(KIND_STORE, SC_WORD, 1'b0, 32'h0001_0000, 32'hC0DE_8001);
    put_access(KIND_LOAD,  SC_WORD, 1'b1, 32'h0001_0000, 32'h0);
    put_access(KIND_LOAD,  SC_WORD, 1'b0, 32'h0001_0000, 32'h0);
    put_access(KIND_STORE, SC_BYTE, 1'b0, 32'h0001_0005, 32'hFFFF_FF85);
    put_access(KIND_LOAD,  SC_BYTE, 1'b1, 32'h0001_0005, 32'h0);
    put_access(KIND_LOAD,  SC_BYTE, 1'b0, 32'h0001_0005, 32'h0);
    put_access(KIND_STORE, SC_HALF, 1'b1, 32'h0001_0006, 32'h1234_9234);
    put_access(KIND_LOAD,  SC_HALF, 1'b1, 32'h0001_0006, 32'h0);
    put_access(KIND_LOAD,  SC_HALF, 1'b0, 32'h0001_0004, 32'h0);
    put_access(KIND_LOAD,  SC_HALF, 1'b0, 32'h0001_0001, 32'h0);
    put_access(KIND_STORE, SC_WORD, 1'b0, 32'h0001_0002, 32'hFFFF_FFFF);
    put_access(KIND_STORE, SC_WORD, 1'b0, 32'h0000_1000, 32'hFFFF_FFFF);
    put_access(KIND_LOAD,  SC_WORD, 1'b0, 32'hFFFF_FFFC, 32'h0);
    put_access(KIND_STORE, SC_BYTE, 1'b0, 32'hFFFF_FFFF, 32'h0000_00AA);
    put_access(KIND_STORE, SC_BYTE, 1'b0, 32'hFFFF_FFFE, 32'h0000_0080);
    put_access(KIND_LOAD,  SC_BYTE, 1'b1, 32'hFFFF_FFFE, 32'h0);
    put_access(KIND_LOAD,  SC_SPARE, 1'b1, 32'h0001_0004, 32'h0);
    put_access(KIND_NONE,  SC_WORD, 1'b1, 32'h0001_0000, 32'hFFFF_FFFF);
    // heap base aliases onto the text window in memory
    put_access(KIND_STORE, SC_WORD, 1'b0, 32'h0004_1000, 32'h7F00_00FF);
    put_access(KIND_FETCH, SC_WORD, 1'b0, 32'h0000_1000, 32'h0);
    put_access(KIND_LOAD,  SC_WORD, 1'b0, 32'h0001_03FC, 32'h0);
    put_access(KIND_LOAD,  SC_WORD, 1'b0, 32'h0001_0400, 32'h0);
  endtask

  initial begin : rx_side
    int   idle_left;
    logic held;
    idle_left = 0;
    held = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_mode == RX_HOLD && !held) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
        held = 1'b1;
      end else if (rx_mode == RX_OPEN || (idle_left == 0 && $urandom_range(0, 7) != 0)) begin
        out_ready <= 1'b1;
      end else begin
        if (idle_left == 0)
          idle_left = $urandom_range(1, 13);
        out_ready <= 1'b0;
        idle_left--;
      end
    end
  end

  initial begin : stimulus
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_kind       <= KIND_FETCH;
    in_size_code  <= SC_WORD;
    in_is_signed  <= 1'b0;
    in_address    <= 32'h0;
    in_store_data <= 32'h0;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= REG_TEXT_LO;
    cfg_wdata     <= 32'h0;
    rx_mode       <= RX_RANDOM;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    load_windows(WIN_A);
    run_directed();
    settle();
    run_random(120);

    // stall the result side long enough to back up the block
    rx_mode <= RX_HOLD;
    tx_gaps = 1'b0;
    run_random(40);
    rx_mode <= RX_RANDOM;
    tx_gaps = 1'b1;
    run_random(90);
    settle();

    load_windows(WIN_FULL);
    run_random(150);
    settle();
    load_windows(WIN_SHUT);
    run_random(60);
    settle();
    repeat (2) begin
      load_windows(random_windows());
      run_random(100);
      settle();
    end

    load_windows(WIN_A);
    rx_mode <= RX_OPEN;
    tx_gaps = 1'b0;
    run_random(150);
    settle();

    $display("%0d accesses over %0d window settings, %0d results compared",
             n_sent, n_settings, n_checked);
    if (n_fail == 0 && n_pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
src/clsu_pkg.sv
src/clsu_ram.sv
src/clsu_fifo.sv
src/clsu_front.sv
src/clsu_back.sv
src/checked_load_store_unit_core.sv
test/lsu_result_checker.sv
test/tb_checked_load_store_unit_core.sv
